// ===== rtl/core/rtc3w_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Shared types and constants for the three-wire clock chip serial master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

  // input kind codes as they arrive on the port
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [7:0] CMD_BASE     = 8'h80;
  localparam logic [7:0] BCD_SATURATE = 8'h99;
  localparam logic [7:0] BIN_MAX      = 8'd99;
  localparam logic [7:0] SECONDS_MASK = 8'h7F;
  localparam logic [2:0] LAST_BIT     = 3'd7;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_DATA
  } phase_t;

  // one classified word as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] command;
    logic [7:0] data;
    logic       convert;
    logic       seconds;
    logic       din;
  } rtc_item_t;

  typedef struct packed {
    logic       clock_out;
    logic       data_out;
    logic       data_drive;
    logic       chip_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
    logic       rejected;
  } rtc_result_t;

endpackage

// ===== rtl/core/three_wire_rtc_serial_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Three-wire serial master for a clock chip, paced by tick words.
//
//   channel  signals                                       handshake
//   input    kind reg_number write_data convert_bcd data_in in_valid/in_ready
//   output   clock_out ... rejected                        out_valid/out_ready
//   config   cfg_data (half period in ticks)               cfg_we, no wait
//
// One word per cycle while the output is not stalled; a word's result reaches
// the output through the queue, then the sequencer output register.
// The sequencer takes one queued word per cycle whenever the output register
// is empty or being drained.
// Synchronous reset clears the queue and the sequencer and sets the half period to 1.
// A stalled output holds the sequencer; the queue then fills and drops in_ready.
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master
  import rtc3w_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [4:0]  reg_number,
  input  logic [7:0]  write_data,
  input  logic        convert_bcd,
  input  logic        data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        clock_out,
  output logic        data_out,
  output logic        data_drive,
  output logic        chip_enable,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_result,
  output logic        rejected
);

  logic        push_valid;
  logic        push_ready;
  rtc_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  rtc_item_t   pop_item;
  rtc_result_t res;

  rtc3w_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .reg_number (reg_number),
    .write_data (write_data),
    .convert_bcd(convert_bcd),
    .data_in    (data_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rtc3w_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  rtc3w_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_item (pop_item),
    .res_valid(out_valid),
    .res_ready(out_ready),
    .res      (res)
  );

  assign clock_out   = res.clock_out;
  assign data_out    = res.data_out;
  assign data_drive  = res.data_drive;
  assign chip_enable = res.chip_enable;
  assign busy_res    = res.busy_res;
  assign done_res    = res.done_res;
  assign read_result = res.read_result;
  assign rejected    = res.rejected;

endmodule

// ===== rtl/core/rtc3w_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc3w_front
// Classifies incoming words and builds command and write bytes for the queue.
// ----------------------------------------------------------------------------
module rtc3w_front
  import rtc3w_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [4:0] reg_number,
  input  logic [7:0] write_data,
  input  logic       convert_bcd,
  input  logic       data_in,
  output logic       push_valid,
  input  logic       push_ready,
  output rtc_item_t  push_item
);

  logic [15:0] tens_prod;
  logic [3:0]  tens;
  logic [7:0]  ones_full;
  logic [7:0]  bcd_value;
  op_t         op;

  // divide by ten via reciprocal, exact for values up to 99
  assign tens_prod = {8'd0, write_data} * 16'd205;
  assign tens      = tens_prod[14:11];
  assign ones_full = write_data - ({1'b0, tens, 3'b000} + {3'b000, tens, 1'b0});
  assign bcd_value = (write_data > BIN_MAX) ? BCD_SATURATE : {tens, ones_full[3:0]};

  always_comb begin
    unique case (kind)
      KIND_WRITE: op = OP_WRITE;
      KIND_READ:  op = OP_READ;
      KIND_TICK:  op = OP_TICK;
      default:    op = OP_NONE;
    endcase
  end

  always_comb begin
    push_item.op      = op;
    push_item.command = CMD_BASE | {2'b00, reg_number, 1'b0} | {7'd0, kind[0]};
    push_item.convert = convert_bcd;
    push_item.seconds = (reg_number == 5'd0);
    push_item.din     = data_in;
    if (op == OP_READ) begin
      push_item.data = 8'd0;
    end else if (convert_bcd) begin
      push_item.data = bcd_value;
    end else begin
      push_item.data = write_data;
    end
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== rtl/core/rtc3w_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc3w_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module rtc3w_queue
  import rtc3w_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  rtc_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output rtc_item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtc_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rtc3w_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc3w_back
// Serial sequencer: one queued word per cycle while the output register is free, results into it.
// ----------------------------------------------------------------------------
module rtc3w_back
  import rtc3w_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  rtc_item_t   pop_item,
  output logic        res_valid,
  input  logic        res_ready,
  output rtc_result_t res
);

  phase_t      phase, phase_next;
  logic [2:0]  bit_count, bit_count_next;
  logic        clock_level, clock_level_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  command_shift, command_shift_next;
  logic [7:0]  data_shift, data_shift_next;
  logic        is_read, is_read_next;
  logic        do_convert, do_convert_next;
  logic        seconds_target, seconds_target_next;
  logic        enable_level, enable_level_next;
  logic        drive_level, drive_level_next;
  logic [15:0] half_period_ticks;

  logic        step;
  logic        busy;
  logic        busy_next;
  logic [15:0] hp;
  logic [15:0] tick_inc;
  logic [7:0]  masked;
  logic [7:0]  decoded;
  logic        done;
  logic        rej;
  logic [7:0]  result;
  logic        dout;
  rtc_result_t res_next;

  assign step      = pop_valid && (!res_valid || res_ready);
  assign pop_ready = !res_valid || res_ready;
  assign busy      = (phase != PH_IDLE);
  assign hp        = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign tick_inc  = tick_count + 16'd1;

  // bcd to binary: low nibble plus ten times high nibble
  assign masked  = seconds_target ? (data_shift & SECONDS_MASK) : data_shift;
  assign decoded = {4'd0, masked[3:0]} + {1'b0, masked[7:4], 3'b000}
                 + {3'b000, masked[7:4], 1'b0};

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    clock_level_next    = clock_level;
    tick_count_next     = tick_count;
    command_shift_next  = command_shift;
    data_shift_next     = data_shift;
    is_read_next        = is_read;
    do_convert_next     = do_convert;
    seconds_target_next = seconds_target;
    enable_level_next   = enable_level;
    drive_level_next    = drive_level;
    done                = 1'b0;
    rej                 = 1'b0;
    result              = 8'd0;

    unique case (pop_item.op)
      OP_WRITE, OP_READ: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          is_read_next        = (pop_item.op == OP_READ);
          do_convert_next     = pop_item.convert;
          seconds_target_next = pop_item.seconds;
          command_shift_next  = pop_item.command;
          data_shift_next     = pop_item.data;
          enable_level_next   = 1'b1;
          drive_level_next    = 1'b1;
          clock_level_next    = 1'b0;
          tick_count_next     = 16'd0;
          bit_count_next      = 3'd0;
          phase_next          = PH_CMD;
        end
      end
      OP_TICK: begin
        if (busy) begin
          if (tick_inc >= hp) begin
            tick_count_next = 16'd0;
            if (!clock_level) begin
              // rising edge: sample the line on reads
              if (phase == PH_DATA && is_read) begin
                data_shift_next = {pop_item.din, data_shift[7:1]};
              end
              clock_level_next = 1'b1;
            end else begin
              clock_level_next = 1'b0;
              if (phase == PH_CMD) begin
                command_shift_next = {1'b0, command_shift[7:1]};
              end else if (!is_read) begin
                data_shift_next = {1'b0, data_shift[7:1]};
              end
              if (bit_count == LAST_BIT) begin
                bit_count_next = 3'd0;
                if (phase == PH_CMD) begin
                  phase_next = PH_DATA;
                  if (is_read) begin
                    drive_level_next = 1'b0;
                  end
                end else begin
                  if (is_read) begin
                    result = do_convert ? decoded : data_shift;
                  end
                  done              = 1'b1;
                  phase_next        = PH_IDLE;
                  enable_level_next = 1'b0;
                  drive_level_next  = 1'b1;
                end
              end else begin
                bit_count_next = bit_count + 3'd1;
              end
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_next = (phase_next != PH_IDLE);

  always_comb begin
    dout = 1'b0;
    if (busy_next && drive_level_next) begin
      dout = (phase_next == PH_CMD) ? command_shift_next[0] : data_shift_next[0];
    end
    res_next.clock_out   = clock_level_next;
    res_next.data_out    = dout;
    res_next.data_drive  = drive_level_next;
    res_next.chip_enable = enable_level_next;
    res_next.busy_res    = busy_next;
    res_next.done_res    = done;
    res_next.read_result = result;
    res_next.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count         <= 3'd0;
      clock_level       <= 1'b0;
      tick_count        <= 16'd0;
      enable_level      <= 1'b0;
      drive_level       <= 1'b1;
      half_period_ticks <= 16'd1;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_period_ticks <= cfg_data;
      end
      if (step) begin
        bit_count    <= bit_count_next;
        clock_level  <= clock_level_next;
        tick_count   <= tick_count_next;
        enable_level <= enable_level_next;
        drive_level  <= drive_level_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      command_shift  <= command_shift_next;
      data_shift     <= data_shift_next;
      is_read        <= is_read_next;
      do_convert     <= do_convert_next;
      seconds_target <= seconds_target_next;
      res            <= res_next;
    end
  end

endmodule
